### src/feedback_frame_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// Feedback frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_FRAME_PARSER_UNIT_DEFINES_SVH
`define FEEDBACK_FRAME_PARSER_UNIT_DEFINES_SVH

// General property check
`define FFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Hold check: while a beat is offered and stalled, the signal keeps its value
`define FFP_ASSERT_HOLD(lbl, vld, stl, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && (stl)) |=> $stable(sig)) else $error(msg);

`endif

### src/ffp_pkg.sv
// ----------------------------------------------------------------------------
// Feedback frame parser package
// Frame geometry, beat types and the decoded result record.
// ----------------------------------------------------------------------------
package ffp_pkg;

	localparam int FRAME_LENGTH = 16;
	localparam int POS_W        = $clog2(FRAME_LENGTH);

	localparam logic [POS_W-1:0] POS_FIRST_BODY = POS_W'(1);
	localparam logic [POS_W-1:0] POS_CSUM_LO    = POS_W'(FRAME_LENGTH - 2);
	localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_LENGTH - 1);

	localparam logic [7:0] HEADER_RESET = 8'hAA;

	typedef struct packed {
		logic [1:0]         status_bits;
		logic signed [7:0]  wheel_spd_l;
		logic signed [7:0]  wheel_spd_r;
		logic [13:0]        tick_left;
		logic [13:0]        tick_right;
		logic [6:0]         temperature;
		logic [10:0]        current;
		logic [6:0]         battery;
		logic               charging;
		logic [5:0]         aux_small;
		logic [15:0]        aux_wide;
	} ffp_result_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] data;
	} ffp_byte_beat_t;

	typedef struct packed {
		logic        vld;
		ffp_result_t res;
	} ffp_res_beat_t;

endpackage

### src/feedback_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// Feedback frame parser unit
// Hunts for the header byte, collects a 16-byte feedback frame, checks the
// XOR fold checksum and emits the decoded fields of each good frame.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_stall, rx_byte     | byte in
//   out     | out_valid, out_stall, fields    | result out
//   cfg     | cfg_valid, cfg_ready, header_byte | write in
//
// One byte per cycle sustained while the output is not held stalled. A
// byte is registered at the input, runs through the fold and decode
// logic, and its result is loaded into the output register, raising
// out_valid, once that register is free. in_stall rises only while a
// result is held and stalled with a byte waiting. Reset restores header
// 0xAA and the hunt state; config writes are always ready.
// ----------------------------------------------------------------------------
module feedback_frame_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status_bits,
	output logic signed [7:0]  wheel_spd_l,
	output logic signed [7:0]  wheel_spd_r,
	output logic [13:0]        tick_left,
	output logic [13:0]        tick_right,
	output logic [6:0]         temperature,
	output logic [10:0]        current,
	output logic [6:0]         battery,
	output logic               charging,
	output logic [5:0]         aux_small,
	output logic [15:0]        aux_wide,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         header_byte
);
	import ffp_pkg::*;

	logic [7:0]     header_val_q;
	ffp_byte_beat_t beat_s1;
	ffp_res_beat_t  res_beat;
	ffp_result_t    res_q;
	logic           out_free;
	logic           advance;

	assign cfg_ready = 1'b1;
	assign advance   = beat_s1.vld && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_val_q <= HEADER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			header_val_q <= header_byte;
		end
	end

	ffp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rx_byte  (rx_byte),
		.out_free (out_free),
		.in_stall (in_stall),
		.beat_s1  (beat_s1)
	);

	ffp_frame_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat_s1     (beat_s1),
		.advance     (advance),
		.header_byte (header_val_q),
		.res_beat    (res_beat)
	);

	ffp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_beat  (res_beat),
		.advance   (advance),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign status_bits = res_q.status_bits;
	assign wheel_spd_l = res_q.wheel_spd_l;
	assign wheel_spd_r = res_q.wheel_spd_r;
	assign tick_left   = res_q.tick_left;
	assign tick_right  = res_q.tick_right;
	assign temperature = res_q.temperature;
	assign current     = res_q.current;
	assign battery     = res_q.battery;
	assign charging    = res_q.charging;
	assign aux_small   = res_q.aux_small;
	assign aux_wide    = res_q.aux_wide;

endmodule

### src/ffp_in_stage.sv
// ----------------------------------------------------------------------------
// Feedback frame parser input stage
// Registers one received byte per beat; stalls only on result backpressure.
// ----------------------------------------------------------------------------
module ffp_in_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [7:0]             rx_byte,
	input  logic                   out_free,
	output logic                   in_stall,
	output ffp_pkg::ffp_byte_beat_t beat_s1
);
	import ffp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign beat_s1.vld  = valid_s1;
	assign beat_s1.data = byte_s1;

endmodule

### src/ffp_frame_core.sv
// ----------------------------------------------------------------------------
// Feedback frame parser frame core
// Header hunt, byte position, running XOR fold, frame store and field decode.
// ----------------------------------------------------------------------------
module ffp_frame_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ffp_pkg::ffp_byte_beat_t beat_s1,
	input  logic                    advance,
	input  logic [7:0]              header_byte,
	output ffp_pkg::ffp_res_beat_t  res_beat
);
	import ffp_pkg::*;

	logic             in_body_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      fold_q;
	logic [7:0]       store_q [FRAME_LENGTH];

	logic [7:0]  b;
	logic [15:0] fold_term;
	logic [31:0] word_t;
	logic [31:0] word_m;
	logic        frame_end;

	assign b         = beat_s1.data;
	assign fold_term = pos_q[0] ? {b, 8'h00} : {8'h00, b};
	assign frame_end = in_body_q && (pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			pos_q     <= '0;
			fold_q    <= '0;
		end else if (advance) begin
			if (!in_body_q) begin
				if (b == header_byte) begin
					in_body_q <= 1'b1;
					pos_q     <= POS_FIRST_BODY;
					fold_q    <= {8'h00, b};
				end
			end else if (pos_q == POS_LAST) begin
				in_body_q <= 1'b0;
				pos_q     <= '0;
				fold_q    <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (pos_q < POS_CSUM_LO) begin
					fold_q <= fold_q ^ fold_term;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_body_q) begin
			store_q[pos_q] <= b;
		end
	end

	assign word_t = {store_q[7], store_q[6], store_q[5], store_q[4]};
	assign word_m = {store_q[11], store_q[10], store_q[9], store_q[8]};

	always_comb begin
		res_beat.vld                 = frame_end && ({b, store_q[14]} == fold_q);
		res_beat.res.status_bits     = store_q[1][1:0];
		res_beat.res.wheel_spd_l     = store_q[2];
		res_beat.res.wheel_spd_r     = store_q[3];
		res_beat.res.tick_left       = word_t[13:0];
		res_beat.res.tick_right      = word_t[27:14];
		res_beat.res.temperature     = word_m[6:0];
		res_beat.res.current         = word_m[17:7];
		res_beat.res.battery         = word_m[24:18];
		res_beat.res.charging        = word_m[25];
		res_beat.res.aux_small       = word_m[31:26];
		res_beat.res.aux_wide        = {store_q[13], store_q[12]};
	end

endmodule

### src/ffp_out_stage.sv
// ----------------------------------------------------------------------------
// Feedback frame parser output stage
// Result register; frees when empty or when the held beat is taken.
// ----------------------------------------------------------------------------
module ffp_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ffp_pkg::ffp_res_beat_t res_beat,
	input  logic                   advance,
	input  logic                   out_stall,
	output logic                   out_free,
	output logic                   out_valid,
	output ffp_pkg::ffp_result_t   res_q
);
	import ffp_pkg::*;

	logic out_valid_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_beat.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_beat.vld) begin
			res_q <= res_beat.res;
		end
	end

endmodule

### src/ffp_checker.sv
// ----------------------------------------------------------------------------
// Feedback frame parser port checker
// Watches the top-level ports for handshake and backpressure behavior.
// ----------------------------------------------------------------------------
`include "feedback_frame_parser_unit_defines.svh"

module ffp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] aux_wide,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	`FFP_ASSERT_HOLD(a_out_valid_hold, out_valid, out_stall, out_valid, "out beat dropped while stalled")
	`FFP_ASSERT_HOLD(a_out_data_hold, out_valid, out_stall, aux_wide, "out payload moved while stalled")
	`FFP_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without output backpressure")
	`FFP_ASSERT(a_result_move, $rose(out_valid) |-> $past(!in_stall), "result loaded while pipeline was blocked")
	`FFP_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "config beat refused")

endmodule

bind feedback_frame_parser_unit ffp_checker u_ffp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.aux_wide  (aux_wide),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
